[sv/lobm_pkg.sv]
package lobm_pkg;

  localparam int ID_W    = 10;
  localparam int PRICE_W = 12;
  localparam int QTY_W   = 32;
  localparam int OUTC_W  = 3;
  localparam int FILLS_W = 10;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 104;

  localparam logic [FILLS_W-1:0] FILLS_MAX = '1;

  localparam logic [OUTC_W-1:0] OUTC_RESTED    = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_FILLED    = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_CANCELLED = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_UNKNOWN   = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_BUSY      = 3'd4;
  localparam logic [OUTC_W-1:0] OUTC_ZERO_QTY  = 3'd5;

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_CANCEL = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

endpackage

[sv/limit_order_book_matcher_unit.sv]
// price-time priority limit order book
// in channel: one transfer per submit or cancel; out channel: one result per item
// after reset a clearing pass wipes the slot and level memories; in_tready stays
// low meanwhile. order slots and price levels live in two memories with registered
// reads, and every step is a read, modify and write back sequenced by one state
// machine. a reject or a zero quantity goes straight to the result; a cancel
// unlinks the order from its level; a submit walks the opposite levels from the
// best price, consumes resting orders oldest first, may partly fill one resting
// order, and rests any remainder. emptying the best level of a side walks the
// price levels one at a time to find the next nonempty one (up to PRICE_TICKS).
// one item is in work at a time; the result sits in an output register so a
// stalled receiver only holds the block once the next result is ready. best
// bid and ask are kept in registers and reported with every result.
module limit_order_book_matcher_unit
  import lobm_pkg::*;
#(
  parameter int MAX_ORDERS  = 1024,
  parameter int PRICE_TICKS = 4096,
  parameter int QTY_BITS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // order_id[9:0], side[10], price[22:11], quantity[54:23]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // filled_qty[31:0], remaining_qty[63:32], fills_count[73:64], best_bid_valid[74],
  // best_bid_price[86:75], best_ask_valid[87], best_ask_price[99:88]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // outcome[2:0]
  output logic [OUTC_W-1:0]     out_tuser
);

  localparam int IDW   = $clog2(MAX_ORDERS);
  localparam int LW    = $clog2(MAX_ORDERS + 1);
  localparam int PW    = $clog2(PRICE_TICKS);
  localparam int LVW   = PW + 1;
  localparam int LVD   = 2 ** LVW;
  localparam int QW    = (QTY_BITS < QTY_W) ? QTY_BITS : QTY_W;
  localparam int CLR_N = (LVD > MAX_ORDERS) ? LVD : MAX_ORDERS;
  localparam int CW    = $clog2(CLR_N + 1);

  localparam logic [LW-1:0] NO_LINK = LW'(MAX_ORDERS);
  localparam logic [PW-1:0] TOP_PRICE = PW'(PRICE_TICKS - 1);

  typedef struct packed {
    logic          live;
    logic          side;
    logic [PW-1:0] price;
    logic [QW-1:0] qty;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } slot_t;

  typedef struct packed {
    logic           ne;
    logic [IDW-1:0] head;
    logic [IDW-1:0] tail;
  } level_t;

  localparam int SW  = $bits(slot_t);
  localparam int LVB = $bits(level_t);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_MSTART = 4'd3;
  localparam logic [3:0] S_HRD    = 4'd4;
  localparam logic [3:0] S_HCALC  = 4'd5;
  localparam logic [3:0] S_ULV    = 4'd6;
  localparam logic [3:0] S_ULW    = 4'd7;
  localparam logic [3:0] S_UP     = 4'd8;
  localparam logic [3:0] S_UNW    = 4'd9;
  localparam logic [3:0] S_UEND   = 4'd10;
  localparam logic [3:0] S_SCAN   = 4'd11;
  localparam logic [3:0] S_RRD    = 4'd12;
  localparam logic [3:0] S_RLW    = 4'd13;
  localparam logic [3:0] S_RTW    = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  // memory ports
  logic           slot_we;
  logic [IDW-1:0] slot_waddr;
  slot_t          slot_wdata;
  logic [IDW-1:0] slot_raddr;
  slot_t          slot_rdata;
  logic           lvl_we;
  logic [LVW-1:0] lvl_waddr;
  level_t         lvl_wdata;
  logic [LVW-1:0] lvl_raddr;
  level_t         lvl_rdata;

  lobm_ram #(.W(SW), .D(MAX_ORDERS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  lobm_ram #(.W(LVB), .D(LVD)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  // registers
  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic               act_r, act_nxt;
  logic [IDW-1:0]     id_r, id_nxt;
  logic               idok_r, idok_nxt;
  logic               side_r, side_nxt;
  logic [PW-1:0]      price_r, price_nxt;
  logic [QW-1:0]      mqty_r, mqty_nxt;
  logic [QW-1:0]      filled_r, filled_nxt;
  logic [QW-1:0]      rem_r, rem_nxt;
  logic [FILLS_W-1:0] fills_r, fills_nxt;
  logic [OUTC_W-1:0]  outc_r, outc_nxt;
  logic [IDW-1:0]     hd_r, hd_nxt;
  logic [IDW-1:0]     t_r, t_nxt;
  logic [IDW-1:0]     u_id_r, u_id_nxt;
  slot_t              u_e_r, u_e_nxt;
  logic               ret_match_r, ret_match_nxt;
  logic               empt_r, empt_nxt;
  logic               sc_side_r, sc_side_nxt;
  logic [PW-1:0]      cp_r, cp_nxt;
  logic               bid_v_r, bid_v_nxt;
  logic [PW-1:0]      bid_r, bid_nxt;
  logic               ask_v_r, ask_v_nxt;
  logic [PW-1:0]      ask_r, ask_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUTC_W-1:0]  out_outc_r, out_outc_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // input fields
  logic [ID_W-1:0]    in_order_id;
  logic               in_side;
  logic [PRICE_W-1:0] in_price;
  logic [QTY_W-1:0]   in_quantity;
  logic [IDW-1:0]     in_id_idx;
  logic [PW-1:0]      in_price_sat;

  assign in_order_id = in_tdata[9:0];
  assign in_side     = in_tdata[10];
  assign in_price    = in_tdata[22:11];
  assign in_quantity = in_tdata[54:23];
  assign in_id_idx   = IDW'(in_order_id);
  assign in_price_sat = (32'(in_price) > 32'(PRICE_TICKS - 1)) ? TOP_PRICE : PW'(in_price);

  logic           u_pv, u_nv;
  logic [IDW-1:0] u_p_idx, u_n_idx;
  logic [LVW-1:0] u_lv;
  logic [3:0]     post_scan_st;

  assign u_pv    = u_e_r.prv < NO_LINK;
  assign u_nv    = u_e_r.nxt < NO_LINK;
  assign u_p_idx = u_e_r.prv[IDW-1:0];
  assign u_n_idx = u_e_r.nxt[IDW-1:0];
  assign u_lv    = {u_e_r.side, u_e_r.price};
  assign post_scan_st = ret_match_r ? S_MSTART : S_FIN;

  always_comb begin
    slot_t  e;
    level_t ld;
    logic   scan_go;
    logic   scan_sd;

    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    idok_nxt      = idok_r;
    side_nxt      = side_r;
    price_nxt     = price_r;
    mqty_nxt      = mqty_r;
    filled_nxt    = filled_r;
    rem_nxt       = rem_r;
    fills_nxt     = fills_r;
    outc_nxt      = outc_r;
    hd_nxt        = hd_r;
    t_nxt         = t_r;
    u_id_nxt      = u_id_r;
    u_e_nxt       = u_e_r;
    ret_match_nxt = ret_match_r;
    empt_nxt      = empt_r;
    sc_side_nxt   = sc_side_r;
    cp_nxt        = cp_r;
    bid_v_nxt     = bid_v_r;
    bid_nxt       = bid_r;
    ask_v_nxt     = ask_v_r;
    ask_nxt       = ask_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_outc_nxt  = out_outc_r;
    out_data_nxt  = out_data_r;

    slot_we    = 1'b0;
    slot_waddr = u_id_r;
    slot_wdata = '0;
    slot_raddr = '0;
    lvl_we     = 1'b0;
    lvl_waddr  = u_lv;
    lvl_wdata  = '0;
    lvl_raddr  = '0;
    in_tready  = 1'b0;

    e       = slot_rdata;
    ld      = lvl_rdata;
    scan_go = 1'b0;
    scan_sd = 1'b0;

    case (state_r)
      S_CLR: begin
        slot_we    = clr_cnt_r < CW'(MAX_ORDERS);
        slot_waddr = clr_cnt_r[IDW-1:0];
        lvl_we     = clr_cnt_r < CW'(LVD);
        lvl_waddr  = clr_cnt_r[LVW-1:0];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready  = 1'b1;
        slot_raddr = in_id_idx;
        if (in_tvalid) begin
          act_nxt    = in_tuser;
          id_nxt     = in_id_idx;
          idok_nxt   = 32'(in_order_id) < 32'(MAX_ORDERS);
          side_nxt   = in_side;
          price_nxt  = in_price_sat;
          mqty_nxt   = in_quantity[QW-1:0];
          filled_nxt = '0;
          rem_nxt    = '0;
          fills_nxt  = '0;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (act_r == ACT_CANCEL) begin
          if (!idok_r || !e.live) begin
            outc_nxt  = OUTC_UNKNOWN;
            state_nxt = S_FIN;
          end else begin
            outc_nxt      = OUTC_CANCELLED;
            rem_nxt       = e.qty;
            u_id_nxt      = id_r;
            u_e_nxt       = e;
            ret_match_nxt = 1'b0;
            state_nxt     = S_ULV;
          end
        end else if (mqty_r == '0) begin
          outc_nxt  = OUTC_ZERO_QTY;
          state_nxt = S_FIN;
        end else if (!idok_r || e.live) begin
          outc_nxt  = OUTC_BUSY;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        if (mqty_r == '0) begin
          outc_nxt  = OUTC_FILLED;
          state_nxt = S_FIN;
        end else if (side_r == SIDE_BUY && ask_v_r && ask_r <= price_r) begin
          lvl_raddr = {SIDE_SELL, ask_r};
          state_nxt = S_HRD;
        end else if (side_r == SIDE_SELL && bid_v_r && bid_r >= price_r) begin
          lvl_raddr = {SIDE_BUY, bid_r};
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_RRD;
        end
      end
      S_HRD: begin
        hd_nxt     = ld.head;
        slot_raddr = ld.head;
        state_nxt  = S_HCALC;
      end
      S_HCALC: begin
        if (mqty_r < e.qty) begin
          slot_we    = 1'b1;
          slot_waddr = hd_r;
          slot_wdata = e;
          slot_wdata.qty = e.qty - mqty_r;
          filled_nxt = filled_r + mqty_r;
          mqty_nxt   = '0;
          state_nxt  = S_MSTART;
        end else begin
          mqty_nxt   = mqty_r - e.qty;
          filled_nxt = filled_r + e.qty;
          if (fills_r != FILLS_MAX) begin
            fills_nxt = fills_r + 1'b1;
          end
          u_id_nxt      = hd_r;
          u_e_nxt       = e;
          ret_match_nxt = 1'b1;
          state_nxt     = S_ULV;
        end
      end
      S_ULV: begin
        slot_we    = 1'b1;
        slot_waddr = u_id_r;
        slot_wdata = u_e_r;
        slot_wdata.live = 1'b0;
        lvl_raddr  = u_lv;
        state_nxt  = S_ULW;
      end
      S_ULW: begin
        lvl_we    = 1'b1;
        lvl_waddr = u_lv;
        lvl_wdata.ne   = u_pv || u_nv;
        lvl_wdata.head = u_pv ? ld.head : u_n_idx;
        lvl_wdata.tail = u_nv ? ld.tail : u_p_idx;
        empt_nxt  = !(u_pv || u_nv);
        if (u_pv) begin
          slot_raddr = u_p_idx;
          state_nxt  = S_UP;
        end else if (u_nv) begin
          slot_raddr = u_n_idx;
          state_nxt  = S_UNW;
        end else begin
          state_nxt = S_UEND;
        end
      end
      S_UP: begin
        slot_we    = 1'b1;
        slot_waddr = u_p_idx;
        slot_wdata = e;
        slot_wdata.nxt = u_e_r.nxt;
        if (u_nv) begin
          slot_raddr = u_n_idx;
          state_nxt  = S_UNW;
        end else begin
          state_nxt = S_UEND;
        end
      end
      S_UNW: begin
        slot_we    = 1'b1;
        slot_waddr = u_n_idx;
        slot_wdata = e;
        slot_wdata.prv = u_e_r.prv;
        state_nxt  = S_UEND;
      end
      S_UEND: begin
        if (ret_match_r) begin
          if (empt_r) begin
            scan_go = 1'b1;
            scan_sd = ~side_r;
          end else if (mqty_r == '0) begin
            state_nxt = S_MSTART;
          end else begin
            hd_nxt     = u_n_idx;
            slot_raddr = u_n_idx;
            state_nxt  = S_HCALC;
          end
        end else if (empt_r &&
                     ((u_e_r.side == SIDE_BUY && bid_v_r && bid_r == u_e_r.price) ||
                      (u_e_r.side == SIDE_SELL && ask_v_r && ask_r == u_e_r.price))) begin
          scan_go = 1'b1;
          scan_sd = u_e_r.side;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (ld.ne) begin
          if (sc_side_r == SIDE_BUY) begin
            bid_nxt = cp_r;
          end else begin
            ask_nxt = cp_r;
          end
          state_nxt = post_scan_st;
        end else if ((sc_side_r == SIDE_BUY && cp_r == '0) ||
                     (sc_side_r == SIDE_SELL && cp_r == TOP_PRICE)) begin
          if (sc_side_r == SIDE_BUY) begin
            bid_v_nxt = 1'b0;
          end else begin
            ask_v_nxt = 1'b0;
          end
          state_nxt = post_scan_st;
        end else begin
          cp_nxt    = (sc_side_r == SIDE_BUY) ? PW'(cp_r - 1'b1) : PW'(cp_r + 1'b1);
          lvl_raddr = {sc_side_r, cp_nxt};
        end
      end
      S_RRD: begin
        lvl_raddr = {side_r, price_r};
        state_nxt = S_RLW;
      end
      S_RLW: begin
        slot_we    = 1'b1;
        slot_waddr = id_r;
        slot_wdata.live  = 1'b1;
        slot_wdata.side  = side_r;
        slot_wdata.price = price_r;
        slot_wdata.qty   = mqty_r;
        slot_wdata.nxt   = NO_LINK;
        slot_wdata.prv   = ld.ne ? LW'(ld.tail) : NO_LINK;
        lvl_we    = 1'b1;
        lvl_waddr = {side_r, price_r};
        lvl_wdata.ne   = 1'b1;
        lvl_wdata.head = ld.ne ? ld.head : id_r;
        lvl_wdata.tail = id_r;
        if (side_r == SIDE_BUY) begin
          if (!bid_v_r || price_r > bid_r) begin
            bid_v_nxt = 1'b1;
            bid_nxt   = price_r;
          end
        end else if (!ask_v_r || price_r < ask_r) begin
          ask_v_nxt = 1'b1;
          ask_nxt   = price_r;
        end
        rem_nxt  = mqty_r;
        outc_nxt = OUTC_RESTED;
        if (ld.ne) begin
          t_nxt      = ld.tail;
          slot_raddr = ld.tail;
          state_nxt  = S_RTW;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RTW: begin
        slot_we    = 1'b1;
        slot_waddr = t_r;
        slot_wdata = e;
        slot_wdata.nxt = LW'(id_r);
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_outc_nxt  = outc_r;
          out_data_nxt  = '0;
          out_data_nxt[31:0]  = QTY_W'(filled_r);
          out_data_nxt[63:32] = QTY_W'(rem_r);
          out_data_nxt[73:64] = fills_r;
          out_data_nxt[74]    = bid_v_r;
          out_data_nxt[86:75] = bid_v_r ? PRICE_W'(bid_r) : '0;
          out_data_nxt[87]    = ask_v_r;
          out_data_nxt[99:88] = ask_v_r ? PRICE_W'(ask_r) : '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // walk from the emptied best level toward worse prices
    if (scan_go) begin
      sc_side_nxt = scan_sd;
      if (scan_sd == SIDE_BUY) begin
        if (bid_r == '0) begin
          bid_v_nxt = 1'b0;
          state_nxt = post_scan_st;
        end else begin
          cp_nxt    = PW'(bid_r - 1'b1);
          lvl_raddr = {SIDE_BUY, cp_nxt};
          state_nxt = S_SCAN;
        end
      end else begin
        if (ask_r == TOP_PRICE) begin
          ask_v_nxt = 1'b0;
          state_nxt = post_scan_st;
        end else begin
          cp_nxt    = PW'(ask_r + 1'b1);
          lvl_raddr = {SIDE_SELL, cp_nxt};
          state_nxt = S_SCAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      bid_v_r     <= 1'b0;
      ask_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      bid_v_r     <= bid_v_nxt;
      ask_v_r     <= ask_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    id_r        <= id_nxt;
    idok_r      <= idok_nxt;
    side_r      <= side_nxt;
    price_r     <= price_nxt;
    mqty_r      <= mqty_nxt;
    filled_r    <= filled_nxt;
    rem_r       <= rem_nxt;
    fills_r     <= fills_nxt;
    outc_r      <= outc_nxt;
    hd_r        <= hd_nxt;
    t_r         <= t_nxt;
    u_id_r      <= u_id_nxt;
    u_e_r       <= u_e_nxt;
    ret_match_r <= ret_match_nxt;
    empt_r      <= empt_nxt;
    sc_side_r   <= sc_side_nxt;
    cp_r        <= cp_nxt;
    bid_r       <= bid_nxt;
    ask_r       <= ask_nxt;
    out_outc_r  <= out_outc_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_outc_r;

endmodule

[sv/lobm_ram.sv]
module lobm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [(D>1?$clog2(D):1)-1:0]  waddr,
  input  logic [W-1:0]                  wdata,
  input  logic [(D>1?$clog2(D):1)-1:0]  raddr,
  output logic [W-1:0]                  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  assign rdata = rd_r;

endmodule

[test/lobm_checker.sv]
`timescale 1ns / 100ps
module lobm_checker
  import lobm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUTC_W-1:0]     out_tuser,
  output int                    fail_count,
  output int                    pending_count,
  output int                    result_count
);

  localparam int NSLOT = 1024;
  localparam int NTICK = 4096;
  localparam int NONE = NSLOT;

  typedef struct packed {
    logic [OUTC_W-1:0]     outcome;
    logic [OUT_DATA_W-1:0] data;
  } book_result_t;

  // book shadow
  bit          live [NSLOT];
  logic [31:0] oqty [NSLOT];
  logic [11:0] oprice [NSLOT];
  bit          oside [NSLOT];
  int          onext [NSLOT];
  int          oprev [NSLOT];
  bit          lvl_on [2*NTICK];
  int          lvl_head [2*NTICK];
  int          lvl_tail [2*NTICK];

  book_result_t expected_results[$];

  function automatic int lvl_idx(bit s, int p);
    return s * NTICK + p;
  endfunction

  function automatic void drop_order(int id);
    int lv, p, n;
    lv = lvl_idx(oside[id], oprice[id]);
    p = oprev[id];
    n = onext[id];
    if (p != NONE) onext[p] = n; else lvl_head[lv] = n;
    if (n != NONE) oprev[n] = p; else lvl_tail[lv] = p;
    if (p == NONE && n == NONE) lvl_on[lv] = 0;
    live[id] = 0;
  endfunction

  // work one level oldest first; returns 1 when it was emptied
  function automatic bit sweep_level(int lv, ref logic [31:0] q, ref logic [31:0] filled,
                                     ref int fills);
    int h;
    logic [31:0] t;
    while (lvl_on[lv] && q != 0) begin
      h = lvl_head[lv];
      t = (q < oqty[h]) ? q : oqty[h];
      q -= t;
      filled += t;
      oqty[h] -= t;
      if (oqty[h] == 0) begin
        drop_order(h);
        fills++;
      end else begin
        break;
      end
    end
    return !lvl_on[lv];
  endfunction

  function automatic book_result_t match_order(bit act, logic [IN_DATA_W-1:0] d);
    book_result_t r;
    int id, lv, fills;
    bit s;
    logic [11:0] pr;
    logic [31:0] q, filled, rem;
    logic [OUTC_W-1:0] oc;
    logic [9:0] fc;
    bit bv, av;
    logic [11:0] bp, ap;
    id = d[9:0];
    s = d[10];
    pr = d[22:11];
    q = d[54:23];
    filled = 0;
    rem = 0;
    fills = 0;
    if (act == ACT_CANCEL) begin
      if (!live[id]) begin
        oc = OUTC_UNKNOWN;
      end else begin
        rem = oqty[id];
        drop_order(id);
        oc = OUTC_CANCELLED;
      end
    end else if (q == 0) begin
      oc = OUTC_ZERO_QTY;
    end else if (live[id]) begin
      oc = OUTC_BUSY;
    end else begin
      if (s == SIDE_BUY) begin
        for (int p = 0; p <= int'(pr) && q != 0; p++) begin
          lv = lvl_idx(SIDE_SELL, p);
          if (!lvl_on[lv]) continue;
          if (!sweep_level(lv, q, filled, fills)) break;
        end
      end else begin
        for (int p = NTICK - 1; p >= int'(pr) && q != 0; p--) begin
          lv = lvl_idx(SIDE_BUY, p);
          if (!lvl_on[lv]) continue;
          if (!sweep_level(lv, q, filled, fills)) break;
        end
      end
      if (q != 0) begin
        lv = lvl_idx(s, pr);
        live[id] = 1;
        oqty[id] = q;
        oprice[id] = pr;
        oside[id] = s;
        onext[id] = NONE;
        if (!lvl_on[lv]) begin
          lvl_on[lv] = 1;
          lvl_head[lv] = id;
          oprev[id] = NONE;
        end else begin
          onext[lvl_tail[lv]] = id;
          oprev[id] = lvl_tail[lv];
        end
        lvl_tail[lv] = id;
        rem = q;
        oc = OUTC_RESTED;
      end else begin
        oc = OUTC_FILLED;
      end
    end
    fc = (fills > 1023) ? FILLS_MAX : fills[9:0];
    bv = 0; bp = 0; av = 0; ap = 0;
    for (int p = NTICK - 1; p >= 0; p--)
      if (lvl_on[lvl_idx(SIDE_BUY, p)]) begin
        bv = 1; bp = p; break;
      end
    for (int p = 0; p < NTICK; p++)
      if (lvl_on[lvl_idx(SIDE_SELL, p)]) begin
        av = 1; ap = p; break;
      end
    r.outcome = oc;
    r.data = '0;
    r.data[99:0] = {ap, av, bp, bv, fc, rem, filled};
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    book_result_t e;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      expected_results.delete();
      for (int i = 0; i < NSLOT; i++) live[i] = 0;
      for (int i = 0; i < 2*NTICK; i++) lvl_on[i] = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result outcome=%0d data=%h", $time, out_tuser, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e.outcome !== out_tuser || e.data !== out_tdata) begin
            $display("%0t: mismatch expected outcome=%0d data=%h actual outcome=%0d data=%h",
                     $time, e.outcome, e.data, out_tuser, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(match_order(in_tuser, in_tdata));
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import lobm_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUTC_W-1:0]     out_tuser;
  int                    fail_count, pending_count, result_count;
  int                    cycle_count;
  int                    send_idle_pct, recv_idle_pct;
  int                    n_submit, n_cancel;

  localparam int CYCLE_LIMIT = 20000000;

  limit_order_book_matcher_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  lobm_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_order(bit act, int id, bit s, int pr, logic [31:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= {1'b0, q, pr[11:0], s, id[9:0]};
    if (act == ACT_CANCEL) n_cancel++; else n_submit++;
    do @(posedge clk); while (!in_tready);
  endtask

  // a small id pool so cancels and reuse of live ids happen often
  function automatic int pick_id();
    int id;
    id = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(63);
    return id;
  endfunction

  function automatic logic [31:0] pick_qty();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic random_phase(int n);
    int pr;
    for (int i = 0; i < n; i++) begin
      // prices cluster near the middle so books cross often
      pr = ($urandom_range(19) == 0) ? $urandom_range(4095) : 2040 + $urandom_range(16);
      if ($urandom_range(3) == 0)
        send_order(ACT_CANCEL, pick_id(), $urandom_range(1), $urandom_range(4095), $urandom);
      else
        send_order(ACT_SUBMIT, pick_id(), $urandom_range(1), pr, pick_qty());
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = ACT_SUBMIT;
    out_tready = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_submit = 0;
    n_cancel = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, every outcome, multi-level sweeps
    send_order(ACT_CANCEL, 5, SIDE_BUY, 0, 0);
    send_order(ACT_SUBMIT, 1, SIDE_BUY, 100, 0);
    send_order(ACT_SUBMIT, 1023, SIDE_BUY, 0, 32'hFFFF_FFFF);
    send_order(ACT_SUBMIT, 1023, SIDE_SELL, 0, 5);
    send_order(ACT_SUBMIT, 0, SIDE_SELL, 4095, 32'hFFFF_FFFF);
    send_order(ACT_SUBMIT, 2, SIDE_SELL, 10, 3);
    send_order(ACT_SUBMIT, 3, SIDE_SELL, 10, 4);
    send_order(ACT_SUBMIT, 4, SIDE_SELL, 11, 6);
    send_order(ACT_SUBMIT, 5, SIDE_BUY, 11, 10);
    send_order(ACT_SUBMIT, 6, SIDE_BUY, 4095, 20);
    send_order(ACT_SUBMIT, 7, SIDE_SELL, 0, 32'hFFFF_FFFF);
    send_order(ACT_CANCEL, 7, SIDE_SELL, 0, 0);
    send_order(ACT_CANCEL, 0, SIDE_SELL, 0, 0);
    send_order(ACT_CANCEL, 1023, SIDE_SELL, 0, 0);
    send_order(ACT_CANCEL, 0, SIDE_SELL, 0, 0);
    send_order(ACT_SUBMIT, 8, SIDE_BUY, 50, 1);
    send_order(ACT_SUBMIT, 9, SIDE_BUY, 50, 1);
    send_order(ACT_SUBMIT, 10, SIDE_BUY, 50, 1);
    send_order(ACT_CANCEL, 9, SIDE_BUY, 0, 0);
    send_order(ACT_SUBMIT, 11, SIDE_SELL, 40, 2);

    send_idle_pct = 6; recv_idle_pct = 73;
    random_phase(210);
    send_idle_pct = 73; recv_idle_pct = 6;
    random_phase(210);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(210);
    in_tvalid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d submits and %0d cancels, %0d results checked",
             n_submit, n_cancel, result_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[limit_order_book_matcher_unit.f]
sv/lobm_pkg.sv
sv/lobm_ram.sv
sv/limit_order_book_matcher_unit.sv
test/lobm_checker.sv
test/tb_top.sv
